>>> rtl/cfrc_pkg.sv
// ----------------------------------------------------------------------------
// cfrc_pkg
// Shared types and constants of the checksum frame response checker.
// ----------------------------------------------------------------------------
package cfrc_pkg;

    localparam int Q_DEPTH = 2;

    localparam logic [1:0] KIND_BEGIN   = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] ERR_MARKER  = 8'hFF;
    localparam logic [4:0] ID_BASE     = 5'h10;

    localparam logic [8:0] POS_ID      = 9'd3;
    localparam logic [8:0] POS_ERR     = 9'd6;
    localparam logic [8:0] POS_DATA_LO = 9'd8;
    localparam logic [8:0] POS_DATA_HI = 9'd11;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_BEGIN,
        OP_BYTE,
        OP_TIMEOUT
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SYNC,
        PH_LEN,
        PH_BODY
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_LENGTH  = 3'd2,
        ST_MARKER  = 3'd3,
        ST_ID      = 3'd4,
        ST_CKSUM   = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [8:0] expected_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_bytes;
        logic [4:0]  frame_id;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic [8:0] expected_length;
    } t_cmd;

endpackage

>>> rtl/checksum_frame_response_checker_core.sv
// ----------------------------------------------------------------------------
// checksum_frame_response_checker_core
// Receive side of a request/response serial link with sync, length and
// additive checksum; emits one status item per finished or timed-out frame.
//
// Input channel (push/full): one item per cycle. A begin item loads the
// expected frame length and rearms the receiver; byte items feed the frame;
// a timeout item aborts a frame in progress with a timeout status.
// Result channel (empty/pop): status, data bytes 8..11 and the frame id.
//
// The engine takes one item per cycle while the result queue has room.
// With nothing queued ahead, the command queue registers an accepted item,
// the engine takes it from that queue in the next cycle and writes the
// result queue at the end of it, and the result is then on the ports.
// A stalled result side fills the result queue, then the command queue,
// then full rises; nothing is lost. Reset empties both queues, sets the
// receiver idle and clears the id counter.
// ----------------------------------------------------------------------------
module checksum_frame_response_checker_core
    import cfrc_pkg::*;
#(
    parameter int ID_COUNT = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_in,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out
);
    t_cmd      cmd;
    logic      cmd_empty;
    logic      cmd_pop;
    logic      res_full;
    logic      res_push;
    t_out_item res;

    cfrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    cfrc_back #(
        .ID_COUNT (ID_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    cfrc_queue #(
        .T     (t_out_item),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );
endmodule

>>> rtl/cfrc_queue.sv
// ----------------------------------------------------------------------------
// cfrc_queue
// Small register queue with full and empty flags decoded from a registered count.
// ----------------------------------------------------------------------------
module cfrc_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

>>> rtl/cfrc_front.sv
// ----------------------------------------------------------------------------
// cfrc_front
// Accepts input items, decodes the kind and queues commands for the engine.
// ----------------------------------------------------------------------------
module cfrc_front
    import cfrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_in,
    output logic     o_full,
    input  logic     i_cmd_pop,
    output t_cmd     o_cmd,
    output logic     o_cmd_empty
);
    t_cmd cmd;
    logic q_full;

    always_comb begin
        cmd.rx_byte         = i_in.rx_byte;
        cmd.expected_length = i_in.expected_length;
        unique case (i_in.kind)
            KIND_BEGIN:   cmd.op = OP_BEGIN;
            KIND_BYTE:    cmd.op = OP_BYTE;
            KIND_TIMEOUT: cmd.op = OP_TIMEOUT;
            default:      cmd.op = OP_NONE;
        endcase
    end

    // unused kind codes are accepted and dropped here
    cfrc_queue #(
        .T     (t_cmd),
        .DEPTH (Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && (cmd.op != OP_NONE)),
        .i_data  (cmd),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

    assign o_full = q_full;
endmodule

>>> rtl/cfrc_back.sv
// ----------------------------------------------------------------------------
// cfrc_back
// Frame engine: sync search, length, body checks and status generation.
// ----------------------------------------------------------------------------
module cfrc_back
    import cfrc_pkg::*;
#(
    parameter int ID_COUNT = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_res
);
    localparam int CNT_W = $clog2(ID_COUNT);

    t_phase           r_phase, n_phase;
    logic [8:0]       r_want, n_want;
    logic [7:0]       r_left, n_left;
    logic [8:0]       r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [CNT_W-1:0] r_id_cnt, n_id_cnt;
    logic [7:0]       r_seen_id, n_seen_id;
    logic             r_err, n_err;
    logic [31:0]      r_cap, n_cap;
    logic [7:0]       r_blen, n_blen;

    logic             take;
    logic             fin;
    logic             tmo;
    logic [7:0]       b;
    logic [4:0]       cur_id;
    t_status          fin_status;

    assign take   = !i_cmd_empty && !i_res_full;
    assign b      = i_cmd.rx_byte;
    assign cur_id = ID_BASE + 5'(r_id_cnt);
    assign o_cmd_pop = take;

    // datapath
    always_comb begin
        n_want    = r_want;
        n_left    = r_left;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_seen_id = r_seen_id;
        n_err     = r_err;
        n_cap     = r_cap;
        n_blen    = r_blen;
        fin       = 1'b0;
        tmo       = 1'b0;
        if (take) begin
            unique case (i_cmd.op)
                OP_BEGIN: begin
                    n_want    = i_cmd.expected_length;
                    n_left    = '0;
                    n_pos     = '0;
                    n_sum     = '0;
                    n_seen_id = '0;
                    n_err     = 1'b0;
                    n_cap     = '0;
                    n_blen    = '0;
                end
                OP_TIMEOUT: begin
                    tmo = (r_phase != PH_IDLE);
                end
                OP_BYTE: begin
                    unique case (r_phase)
                        PH_SYNC: begin
                            if (b == SYNC_BYTE) begin
                                n_pos = 9'd1;
                            end
                        end
                        PH_LEN: begin
                            n_blen = b;
                            n_left = b;
                            n_pos  = 9'd2;
                            fin    = (b == '0);
                        end
                        PH_BODY: begin
                            if (r_pos == POS_ID) begin
                                n_seen_id = b;
                            end
                            if (r_pos == POS_ERR) begin
                                n_err = (b == ERR_MARKER);
                            end
                            if (r_pos >= POS_DATA_LO && r_pos <= POS_DATA_HI) begin
                                n_cap[8*r_pos[1:0] +: 8] = b;
                            end
                            n_pos = r_pos + 9'd1;
                            if (r_left <= 8'd1) begin
                                n_left = '0;
                                fin    = 1'b1;
                            end else begin
                                n_sum  = r_sum + b;
                                n_left = r_left - 8'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        priority if ({1'b0, n_blen} + 10'd2 != {1'b0, r_want}) begin
            fin_status = ST_LENGTH;
        end else if (n_err) begin
            fin_status = ST_MARKER;
        end else if (n_seen_id != {3'b000, cur_id}) begin
            fin_status = ST_ID;
        end else if (r_sum != b) begin
            fin_status = ST_CKSUM;
        end else begin
            fin_status = ST_OK;
        end
    end

    always_comb begin
        n_id_cnt = r_id_cnt;
        if (fin && fin_status == ST_OK) begin
            n_id_cnt = (r_id_cnt == CNT_W'(ID_COUNT - 1)) ? '0 : r_id_cnt + 1'b1;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (take) begin
            unique case (i_cmd.op)
                OP_BEGIN:   n_phase = PH_SYNC;
                OP_TIMEOUT: n_phase = PH_IDLE;
                OP_BYTE: begin
                    unique case (r_phase)
                        PH_SYNC: n_phase = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC;
                        PH_LEN:  n_phase = fin ? PH_IDLE : PH_BODY;
                        PH_BODY: n_phase = fin ? PH_IDLE : PH_BODY;
                        default: n_phase = r_phase;
                    endcase
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // result outputs
    always_comb begin
        o_res_push     = fin || tmo;
        o_res.frame_id = cur_id;
        if (tmo) begin
            o_res.status     = ST_TIMEOUT;
            o_res.data_bytes = '0;
        end else begin
            o_res.status     = fin_status;
            o_res.data_bytes = (fin_status == ST_OK) ? n_cap : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_want    <= '0;
            r_left    <= '0;
            r_pos     <= '0;
            r_sum     <= '0;
            r_id_cnt  <= '0;
            r_seen_id <= '0;
            r_err     <= 1'b0;
            r_cap     <= '0;
            r_blen    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_want    <= n_want;
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_id_cnt  <= n_id_cnt;
            r_seen_id <= n_seen_id;
            r_err     <= n_err;
            r_cap     <= n_cap;
            r_blen    <= n_blen;
        end
    end

    a_push_needs_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> take)
        else $error("result without a taken item");

    a_begin_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_cmd.op == OP_BEGIN |=> r_phase == PH_SYNC && r_sum == '0)
        else $error("begin did not rearm receiver");

    a_data_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && o_res.status != ST_OK |-> o_res.data_bytes == '0)
        else $error("data on failed frame");

    a_id_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res_push && o_res.status == ST_OK) |=> $stable(r_id_cnt))
        else $error("id counter moved without good frame");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE && !(take && i_cmd.op == OP_BEGIN) |-> !o_res_push)
        else $error("result while idle");
endmodule
